// ----- hdl/rte_pkg.sv -----
// Shared constants, types and helpers for the rigid transform engine.
package rte_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  localparam logic [2:0] CMD_WR_T    = 3'd0;
  localparam logic [2:0] CMD_WR_S    = 3'd1;
  localparam logic [2:0] CMD_COMPOSE = 3'd2;
  localparam logic [2:0] CMD_INVERT  = 3'd3;
  localparam logic [2:0] CMD_POINT   = 3'd4;
  localparam logic [2:0] CMD_RD_T    = 3'd5;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_WR_T = 3'd1;
  localparam logic [2:0] OP_WR_S = 3'd2;
  localparam logic [2:0] OP_RD_T = 3'd3;
  localparam logic [2:0] OP_MAC  = 3'd4;
  localparam logic [2:0] OP_DONE = 3'd5;
  localparam logic [2:0] OP_SKIP = 3'd6;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] cmd;
    logic [1:0] row;
    logic [1:0] col;
    logic       first;
    logic       last;
    logic       capture;
  } rte_ctl_t;

  function automatic logic signed [31:0] ident(input logic [3:0] idx);
    logic signed [31:0] v;
    v = 32'sd0;
    if (idx == 4'd0 || idx == 4'd5 || idx == 4'd10) begin
      v = ONE_FX;
    end
    return v;
  endfunction

endpackage

// ----- hdl/rte_ctrl.sv -----
// Sequencer that steps the datapath through one command.
module rte_ctrl
  import rte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic       out_busy,
  output rte_ctl_t   ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state, state_next;
  logic [2:0] cur_cmd;
  logic [1:0] i, j;
  logic [1:0] k;
  logic [1:0] jmax;
  logic       last_k, last_j, last_i;

  assign in_stall = (state != ST_IDLE) || out_busy;
  assign jmax   = (cur_cmd == CMD_COMPOSE) ? 2'd3 : 2'd0;
  assign last_k = (k == 2'd2);
  assign last_j = (j == jmax);
  assign last_i = (i == 2'd2);

  always_comb begin
    ctl = '0;
    ctl.cmd = cur_cmd;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          case (cmd)
            CMD_WR_T: ctl.op = OP_WR_T;
            CMD_WR_S: ctl.op = OP_WR_S;
            CMD_RD_T: ctl.op = OP_RD_T;
            CMD_COMPOSE, CMD_INVERT, CMD_POINT: begin
              ctl.op = OP_NONE;
              state_next = ST_RUN;
            end
            default: ctl.op = OP_SKIP;
          endcase
        end
      end
      ST_RUN: begin
        ctl.op = OP_MAC;
        ctl.first = (k == 2'd0);
        ctl.last = last_k;
        if (last_k && last_j && last_i) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        ctl.op = OP_DONE;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    ctl.capture = (state == ST_IDLE) && in_valid && !in_stall;
    ctl.row = (state == ST_RUN) ? i : 2'd0;
    ctl.col = (state == ST_RUN) ? j : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cur_cmd <= CMD_WR_T;
      i <= 2'd0;
      j <= 2'd0;
      k <= 2'd0;
    end else begin
      state <= state_next;
      if (ctl.capture) begin
        cur_cmd <= cmd;
        i <= 2'd0;
        j <= 2'd0;
        k <= 2'd0;
      end else if (state == ST_RUN) begin
        if (!last_k) begin
          k <= k + 2'd1;
        end else begin
          k <= 2'd0;
          if (!last_j) begin
            j <= j + 2'd1;
          end else begin
            j <= 2'd0;
            i <= i + 2'd1;
          end
        end
      end
    end
  end

  a_run_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cur_cmd == CMD_COMPOSE || cur_cmd == CMD_INVERT ||
                           cur_cmd == CMD_POINT))
    else $error("sequencer running an element command");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input open while busy");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> (state == ST_IDLE))
    else $error("done state held");

endmodule

// ----- hdl/rte_datapath.sv -----
// Matrix storage, shared multiply-accumulate unit and result register.
module rte_datapath
  import rte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  rte_ctl_t           ctl,
  input  logic [1:0]         row_sel,
  input  logic [1:0]         col_sel,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_busy,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               saturated
);

  logic signed [31:0] tm [12];
  logic signed [31:0] sm [12];
  logic signed [31:0] res [12];
  logic signed [31:0] pt [3];
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [49:0] acc, acc_sum, acc_init;
  logic signed [31:0] sat_val;
  logic               sat_hit, sat_acc;
  logic               out_set;
  logic [3:0]         kj, i3, kk3, ij;
  logic [3:0]         wr_idx;

  assign wr_idx = {row_sel, col_sel};
  assign i3  = {ctl.row, 2'd3};
  assign ij  = {ctl.row, ctl.col};

  logic [1:0] kx;
  always_ff @(posedge clk) begin
    if (ctl.op != OP_MAC || ctl.last) begin
      kx <= 2'd0;
    end else begin
      kx <= kx + 2'd1;
    end
  end
  logic [1:0] kc;
  assign kc  = (ctl.first) ? 2'd0 : kx;
  assign kj  = {kc, ctl.col};
  assign kk3 = {kc, 2'd3};

  always_comb begin
    ma = tm[{ctl.row, kc}];
    mb = sm[kj];
    acc_init = 50'sd0;
    case (ctl.cmd)
      CMD_COMPOSE: begin
        ma = tm[{ctl.row, kc}];
        mb = sm[kj];
        acc_init = (ctl.col == 2'd3) ? 50'(tm[i3]) : 50'sd0;
      end
      CMD_INVERT: begin
        ma = tm[{kc, ctl.row}];
        mb = tm[kk3];
      end
      default: begin
        ma = tm[{ctl.row, kc}];
        mb = pt[kc];
        acc_init = 50'(tm[i3]);
      end
    endcase
  end

  assign prod = ma * mb;
  assign acc_sum = (ctl.first ? acc_init : acc) + 50'(prod >>> FRAC_BITS);

  always_comb begin
    logic signed [49:0] v;
    v = (ctl.cmd == CMD_INVERT) ? -acc_sum : acc_sum;
    sat_hit = 1'b0;
    sat_val = v[31:0];
    if (v > 50'sd2147483647) begin
      sat_hit = 1'b1;
      sat_val = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      sat_hit = 1'b1;
      sat_val = 32'sh80000000;
    end
  end

  assign out_busy = out_valid && out_stall;
  assign out_set = (ctl.op == OP_WR_T) || (ctl.op == OP_WR_S) || (ctl.op == OP_RD_T) ||
                   (ctl.op == OP_DONE) || (ctl.op == OP_SKIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 12; n++) begin
        tm[n] <= ident(4'(n));
        sm[n] <= ident(4'(n));
      end
      out_valid <= 1'b0;
      sat_acc <= 1'b0;
    end else begin
      out_valid <= out_set || (out_valid && out_stall);
      if (ctl.capture) begin
        pt[0] <= px;
        pt[1] <= py;
        pt[2] <= pz;
        sat_acc <= 1'b0;
        if (ctl.op != OP_RD_T) out_x <= 32'sd0;
        out_y <= 32'sd0;
        out_z <= 32'sd0;
        saturated <= 1'b0;
        for (int n = 0; n < 12; n++) begin
          res[n] <= tm[n];
        end
      end
      case (ctl.op)
        OP_WR_T: begin
          if (row_sel != 2'd3) tm[wr_idx] <= elem_value;
        end
        OP_WR_S: begin
          if (row_sel != 2'd3) sm[wr_idx] <= elem_value;
        end
        OP_RD_T: begin
          if (row_sel != 2'd3) begin
            out_x <= tm[wr_idx];
          end else begin
            out_x <= (col_sel == 2'd3) ? ONE_FX : 32'sd0;
          end
        end
        OP_MAC: begin
          acc <= acc_sum;
          if (ctl.last) begin
            if (sat_hit) sat_acc <= 1'b1;
            case (ctl.cmd)
              CMD_COMPOSE: res[ij] <= sat_val;
              CMD_INVERT: res[i3] <= sat_val;
              default: begin
                case (ctl.row)
                  2'd0: out_x <= sat_val;
                  2'd1: out_y <= sat_val;
                  default: out_z <= sat_val;
                endcase
              end
            endcase
          end
        end
        OP_DONE: begin
          saturated <= sat_acc;
          if (ctl.cmd == CMD_COMPOSE) begin
            for (int n = 0; n < 12; n++) tm[n] <= res[n];
          end else if (ctl.cmd == CMD_INVERT) begin
            for (int r = 0; r < 3; r++) begin
              for (int c = 0; c < 3; c++) tm[r*4+c] <= tm[c*4+r];
              tm[r*4+3] <= res[r*4+3];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_busy |-> !ctl.capture)
    else $error("new transfer while result pending");
  a_sat_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> !sat_acc)
    else $error("saturation flag not cleared");

endmodule

// ----- hdl/rigid_transform_engine_unit.sv -----
// Top level of the rigid transform engine.
//   channel | direction | signals
//   input   | in        | in_valid, in_stall, cmd, row_sel, col_sel, elem_value, px, py, pz
//   output  | out       | out_valid, out_stall, out_x, out_y, out_z, saturated
// Element writes and reads are handled directly; point transforms, inversion
// and compose run as multiply-accumulate sequences on the single shared 32x32 multiplier.
// One command is in flight at a time; a held result blocks the next transfer.
// Synchronous reset loads identity into both matrices.
module rigid_transform_engine_unit
  import rte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [1:0]         row_sel,
  input  logic [1:0]         col_sel,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               saturated
);

  rte_ctl_t ctl;
  logic     out_busy;

  rte_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .cmd, .out_busy, .ctl
  );

  rte_datapath u_dp (
    .clk, .rst, .ctl, .row_sel, .col_sel, .elem_value, .px, .py, .pz,
    .out_valid, .out_stall, .out_busy, .out_x, .out_y, .out_z, .saturated
  );

endmodule

// ----- test/rigid_transform_engine_unit_checker.sv -----
// Checker that predicts and compares the results of the rigid transform engine.
`timescale 1ns / 1ps
module rigid_transform_engine_unit_checker
  import rte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [1:0]         row_sel,
  input  logic [1:0]         col_sel,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } point_result_t;

  logic signed [31:0] xform [12];
  logic signed [31:0] stage [12];
  point_result_t      expected_results [$];

  assign pending = expected_results.size();

  function automatic logic signed [63:0] fx_product(logic signed [31:0] a,
                                                    logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clip(logic signed [63:0] v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  task automatic apply_command();
    point_result_t      r;
    logic signed [31:0] nxt [12];
    logic signed [31:0] p [3];
    logic signed [63:0] acc;
    r = '0;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    case (cmd)
      CMD_WR_T: begin
        if (row_sel != 2'd3) xform[row_sel * 4 + col_sel] = elem_value;
      end
      CMD_WR_S: begin
        if (row_sel != 2'd3) stage[row_sel * 4 + col_sel] = elem_value;
      end
      CMD_COMPOSE: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 4; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += fx_product(xform[i*4+k], stage[k*4+j]);
            if (j == 3) acc += 64'(xform[i*4+3]);
            nxt[i*4+j] = clip(acc, r.sat);
          end
        end
        xform = nxt;
      end
      CMD_INVERT: begin
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) nxt[i*4+j] = xform[j*4+i];
          for (int k = 0; k < 3; k++) acc += fx_product(xform[k*4+i], xform[k*4+3]);
          nxt[i*4+3] = clip(-acc, r.sat);
        end
        xform = nxt;
      end
      CMD_POINT: begin
        for (int i = 0; i < 3; i++) begin
          acc = 64'(xform[i*4+3]);
          for (int k = 0; k < 3; k++) acc += fx_product(xform[i*4+k], p[k]);
          if (i == 0) r.x = clip(acc, r.sat);
          if (i == 1) r.y = clip(acc, r.sat);
          if (i == 2) r.z = clip(acc, r.sat);
        end
      end
      CMD_RD_T: begin
        if (row_sel != 2'd3) r.x = xform[row_sel * 4 + col_sel];
        else if (col_sel == 2'd3) r.x = ONE_FX;
      end
      default: begin
      end
    endcase
    expected_results.push_back(r);
  endtask

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    point_result_t e;
    if (rst) begin
      for (int i = 0; i < 12; i++) begin
        xform[i] = ident(4'(i));
        stage[i] = ident(4'(i));
      end
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) apply_command();
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result transfer at %0t", $realtime);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_x !== e.x) report("out_x", out_x, e.x);
          if (out_y !== e.y) report("out_y", out_y, e.y);
          if (out_z !== e.z) report("out_z", out_z, e.z);
          if (saturated !== e.sat) report("saturated", 32'(saturated), 32'(e.sat));
        end
      end
    end
  end

endmodule

// ----- test/rigid_transform_engine_unit_tb.sv -----
// Testbench top for the rigid transform engine: stimulus, reset and verdict.
`timescale 1ns / 1ps
module rigid_transform_engine_unit_tb;
  import rte_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         cmd = '0;
  logic [1:0]         row_sel = '0;
  logic [1:0]         col_sel = '0;
  logic signed [31:0] elem_value = '0;
  logic signed [31:0] px = '0;
  logic signed [31:0] py = '0;
  logic signed [31:0] pz = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               saturated;
  int                 fail_count;
  int                 pending;
  bit                 calm = 1'b0;
  bit                 hold_off = 1'b0;

  always #2 clk = ~clk;

  rigid_transform_engine_unit dut (.*);

  rigid_transform_engine_unit_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b1;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= !calm && ($urandom_range(99) < 23);
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return ONE_FX;
      3: return -ONE_FX;
      4, 5: return $signed($urandom_range(2 * ONE_FX)) - ONE_FX;
      6: return $signed($urandom_range(32'h01000000)) - 32'sh00800000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [2:0] c, logic [1:0] r, logic [1:0] k, logic signed [31:0] v,
                      logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    row_sel <= r;
    col_sel <= k;
    elem_value <= v;
    px <= x;
    py <= y;
    pz <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30)
      send(CMD_POINT, 2'($urandom), 2'($urandom), $urandom, pick_value(), pick_value(),
           pick_value());
    else if (sel < 50)
      send(CMD_WR_T, 2'($urandom_range(2)), 2'($urandom), pick_value(), $urandom, $urandom,
           $urandom);
    else if (sel < 62)
      send(CMD_WR_S, 2'($urandom_range(2)), 2'($urandom), pick_value(), $urandom, $urandom,
           $urandom);
    else if (sel < 72)
      send(CMD_COMPOSE, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom);
    else if (sel < 80)
      send(CMD_INVERT, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom);
    else if (sel < 94)
      send(CMD_RD_T, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom);
    else
      send(3'($urandom), 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    #2000000;
    $display("** rigid_transform_engine_unit: FAILED **");
    $finish;
  end

  initial begin
    int wait_cycles;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(CMD_RD_T, 2'd0, 2'd0, 0, 0, 0, 0);
    send(CMD_RD_T, 2'd3, 2'd3, 0, 0, 0, 0);
    send(CMD_RD_T, 2'd3, 2'd1, 0, 0, 0, 0);
    send(CMD_POINT, 2'd0, 2'd0, 0, 32'sh7fffffff, 32'sh80000000, ONE_FX);
    send(CMD_WR_T, 2'd3, 2'd3, 32'sh12345678, 0, 0, 0);
    send(CMD_WR_T, 2'd0, 2'd3, 32'sh7fffffff, 0, 0, 0);
    send(CMD_WR_T, 2'd1, 2'd3, 32'sh80000000, 0, 0, 0);
    send(CMD_POINT, 2'd0, 2'd0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send(CMD_WR_S, 2'd2, 2'd2, 32'sh7fffffff, 0, 0, 0);
    send(CMD_WR_S, 2'd3, 2'd0, -1, 0, 0, 0);
    send(CMD_COMPOSE, 2'd0, 2'd0, 0, 0, 0, 0);
    send(CMD_INVERT, 2'd0, 2'd0, 0, 0, 0, 0);
    send(CMD_RD_T, 2'd2, 2'd3, 0, 0, 0, 0);
    send(CMD_SPARE_A, 2'd1, 2'd1, -1, -1, -1, -1);
    send(CMD_SPARE_B, 2'd2, 2'd2, -1, -1, -1, -1);
    send(CMD_WR_T, 2'd0, 2'd0, 32'sh80000000, 0, 0, 0);
    send(CMD_INVERT, 2'd0, 2'd0, 0, 0, 0, 0);
    send(CMD_POINT, 2'd0, 2'd0, 0, -1, -1, -1);
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 6; n++) send_random();
    join
    for (int n = 0; n < 830; n++) begin
      calm = (n >= 300 && n < 420);
      send_random();
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** rigid_transform_engine_unit: PASSED **");
    end else begin
      $display("** rigid_transform_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
